/* rtl/core/ptbl_pkg.sv */
package ptbl_pkg;

   localparam int NUM_CLIENTS_DEFAULT = 256;

   localparam int TOKEN_W  = 32;
   localparam int STAMP_W  = 32;
   localparam int WINDOW_W = 16;
   localparam int INDEX_W  = 16;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 3;

   localparam logic [TOKEN_W-1:0]  REFILL_RESET = 32'd1000;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd10;

   // register index, taken from paddr[2]
   localparam logic REG_REFILL = 1'b0;
   localparam logic REG_WINDOW = 1'b1;

   localparam logic CMD_REQUEST = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   typedef struct packed {
      logic               valid;
      logic [STAMP_W-1:0] stamp;
      logic [TOKEN_W-1:0] tokens;
   } bucket_type;

endpackage

/* rtl/core/ptbl_csr.sv */
module ptbl_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ptbl_pkg::ADDR_W-1:0]   paddr,
   input  logic [ptbl_pkg::DATA_W-1:0]   pwdata,
   output logic [ptbl_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output logic [ptbl_pkg::TOKEN_W-1:0]  refill_tokens,
   output logic [ptbl_pkg::WINDOW_W-1:0] window_ticks
);

   logic [ptbl_pkg::TOKEN_W-1:0]  refill_ff, refill_in;
   logic [ptbl_pkg::WINDOW_W-1:0] window_ff, window_in;
   logic                          wr_en;
   logic                          reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_sel = paddr[2];

   always_comb begin
      refill_in = refill_ff;
      window_in = window_ff;
      if (wr_en) begin
         case (reg_sel)
            ptbl_pkg::REG_REFILL: refill_in = pwdata[ptbl_pkg::TOKEN_W-1:0];
            ptbl_pkg::REG_WINDOW: window_in = pwdata[ptbl_pkg::WINDOW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         ptbl_pkg::REG_REFILL: prdata = refill_ff;
         ptbl_pkg::REG_WINDOW:
            prdata = {{(ptbl_pkg::DATA_W-ptbl_pkg::WINDOW_W){1'b0}}, window_ff};
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refill_ff <= ptbl_pkg::REFILL_RESET;
         window_ff <= ptbl_pkg::WINDOW_RESET;
      end else begin
         refill_ff <= refill_in;
         window_ff <= window_in;
      end
   end

   assign refill_tokens = refill_ff;
   assign window_ticks  = window_ff;

endmodule

/* rtl/core/ptbl_mem.sv */
module ptbl_mem #(
   parameter int NUM_CLIENTS = ptbl_pkg::NUM_CLIENTS_DEFAULT,
   localparam int AW = $clog2(NUM_CLIENTS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output ptbl_pkg::bucket_type rd_data,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  ptbl_pkg::bucket_type wr_data,
   output logic                 clearing
);

   ptbl_pkg::bucket_type bucket_mem_ff [NUM_CLIENTS];
   ptbl_pkg::bucket_type rd_data_ff;

   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   ptbl_pkg::bucket_type mem_wdata;

   // sweep every entry once after reset to drop its valid mark
   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(NUM_CLIENTS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   always_comb begin
      mem_we    = clearing_ff | wr_en;
      mem_waddr = clearing_ff ? clr_cnt_ff : wr_addr;
      mem_wdata = clearing_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bucket_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= bucket_mem_ff[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

/* rtl/core/ptbl_pipe.sv */
module ptbl_pipe #(
   parameter int NUM_CLIENTS = ptbl_pkg::NUM_CLIENTS_DEFAULT,
   localparam int AW = $clog2(NUM_CLIENTS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic [ptbl_pkg::INDEX_W-1:0]  req_client_index,
   input  logic [ptbl_pkg::TOKEN_W-1:0]  req_used_tokens,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_limited,
   output logic [ptbl_pkg::TOKEN_W-1:0]  rsp_remaining_tokens,
   output logic                          rsp_index_error,
   input  logic [ptbl_pkg::TOKEN_W-1:0]  refill_tokens,
   input  logic [ptbl_pkg::WINDOW_W-1:0] window_ticks,
   input  logic                          clearing,
   output logic                          rd_en,
   output logic [AW-1:0]                 rd_addr,
   input  ptbl_pkg::bucket_type          rd_data,
   output logic                          wr_en,
   output logic [AW-1:0]                 wr_addr,
   output ptbl_pkg::bucket_type          wr_data
);

   localparam int IW = ptbl_pkg::INDEX_W;

   // stage 1: item waiting on the table read
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_cmd_ff;
   logic [IW-1:0]                 s1_index_ff;
   logic [ptbl_pkg::TOKEN_W-1:0]  s1_used_ff;
   logic                          s1_fwd_ff;
   ptbl_pkg::bucket_type          s1_fwd_data_ff;

   logic [ptbl_pkg::STAMP_W-1:0]  time_now_ff, time_now_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_limited_ff;
   logic [ptbl_pkg::TOKEN_W-1:0]  rsp_remaining_ff;
   logic                          rsp_index_error_ff;

   logic                          accept;
   logic                          s1_advance;
   logic                          s1_is_req;
   logic                          in_range;
   ptbl_pkg::bucket_type          entry;
   logic [ptbl_pkg::STAMP_W-1:0]  elapsed;
   logic                          do_refill;
   logic [ptbl_pkg::TOKEN_W-1:0]  tokens_cur;
   logic [ptbl_pkg::TOKEN_W-1:0]  tokens_new;
   logic [ptbl_pkg::STAMP_W-1:0]  stamp_new;
   logic                          limited;
   logic                          fwd_hit;

   assign s1_is_req  = (s1_cmd_ff == ptbl_pkg::CMD_REQUEST);
   assign s1_advance = s1_valid_ff & (!s1_is_req | !rsp_valid_ff | rsp_ready);
   assign req_ready  = !clearing & (!s1_valid_ff | s1_advance);
   assign accept     = req_valid & req_ready;

   assign rd_en   = accept;
   assign rd_addr = req_client_index[AW-1:0];

   assign in_range = {1'b0, s1_index_ff} < (IW + 1)'(NUM_CLIENTS);

   // a word written back this cycle is not yet visible to the registered read
   assign entry = s1_fwd_ff ? s1_fwd_data_ff : rd_data;

   always_comb begin
      elapsed    = time_now_ff - entry.stamp;
      do_refill  = !entry.valid ||
                   (elapsed > {{(ptbl_pkg::STAMP_W-ptbl_pkg::WINDOW_W){1'b0}}, window_ticks});
      tokens_cur = do_refill ? refill_tokens : entry.tokens;
      stamp_new  = do_refill ? time_now_ff : entry.stamp;
      limited    = (tokens_cur == '0);
      tokens_new = (tokens_cur > s1_used_ff) ? (tokens_cur - s1_used_ff) : '0;
   end

   assign wr_en          = s1_advance & s1_is_req & in_range;
   assign wr_addr        = s1_index_ff[AW-1:0];
   assign wr_data.valid  = 1'b1;
   assign wr_data.stamp  = stamp_new;
   assign wr_data.tokens = tokens_new;

   assign fwd_hit = wr_en & (wr_addr == req_client_index[AW-1:0]);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      time_now_in = time_now_ff;
      if (s1_advance && !s1_is_req) begin
         time_now_in = time_now_ff + 1'b1;
      end

      rsp_valid_in = rsp_valid_ff & !rsp_ready;
      if (s1_advance && s1_is_req) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         time_now_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         time_now_ff  <= time_now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff      <= req_command;
         s1_index_ff    <= req_client_index;
         s1_used_ff     <= req_used_tokens;
         s1_fwd_ff      <= fwd_hit;
         s1_fwd_data_ff <= wr_data;
      end
      if (s1_advance && s1_is_req) begin
         rsp_limited_ff     <= in_range & limited;
         rsp_remaining_ff   <= in_range ? tokens_new : '0;
         rsp_index_error_ff <= !in_range;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_limited          = rsp_limited_ff;
   assign rsp_remaining_tokens = rsp_remaining_ff;
   assign rsp_index_error      = rsp_index_error_ff;

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_index_error_ff |-> !rsp_limited_ff && rsp_remaining_ff == '0)
      else $error("index error word carries bucket data");

   a_limited_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_limited_ff |-> rsp_remaining_ff == '0)
      else $error("limited word with tokens left");

   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      s1_advance && !s1_is_req |=> time_now_ff == $past(time_now_ff) + 1'b1)
      else $error("tick did not advance time");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready && !wr_en)
      else $error("table access during clearing sweep");

endmodule

/* rtl/core/per_client_token_bucket_limiter_top.sv */
// Per-client token bucket limiter.
// Input channel (req_*): command selects a request for bucket req_client_index
// consuming req_used_tokens (zero is a check only), or one time tick. A tick
// gives no word on the result channel; every request gives exactly one.
// Result channel (rsp_*): rsp_limited is set when the bucket held no tokens
// after any refill, rsp_remaining_tokens is what is left, rsp_index_error
// flags a bucket number of NUM_CLIENTS or more (request ignored).
// Settings: APB port, refill_tokens at 0x0, window_ticks at 0x4.
// Throughput: one word per cycle, ticks and requests alike, while the result
// channel does not stall. The table read is registered with the word and the
// update runs in front of the result register; a write-back to the same
// bucket is forwarded so back-to-back requests stay exact.
// Reset: time and settings return to their defaults; then all NUM_CLIENTS
// table entries are swept once to clear the valid marks, with req_ready low.
// A stalled rsp_ready holds the result register; ticks still pass, one more
// request is taken into the update stage and then req_ready drops until the
// result is taken.
module per_client_token_bucket_limiter_top #(
   parameter int NUM_CLIENTS = ptbl_pkg::NUM_CLIENTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_command,
   input  logic [ptbl_pkg::INDEX_W-1:0] req_client_index,
   input  logic [ptbl_pkg::TOKEN_W-1:0] req_used_tokens,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_limited,
   output logic [ptbl_pkg::TOKEN_W-1:0] rsp_remaining_tokens,
   output logic                         rsp_index_error,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [ptbl_pkg::ADDR_W-1:0]  paddr,
   input  logic [ptbl_pkg::DATA_W-1:0]  pwdata,
   output logic [ptbl_pkg::DATA_W-1:0]  prdata,
   output logic                         pready
);

   localparam int AW = $clog2(NUM_CLIENTS);

   logic [ptbl_pkg::TOKEN_W-1:0]  refill_tokens;
   logic [ptbl_pkg::WINDOW_W-1:0] window_ticks;
   logic                          clearing;
   logic                          rd_en;
   logic [AW-1:0]                 rd_addr;
   ptbl_pkg::bucket_type          rd_data;
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   ptbl_pkg::bucket_type          wr_data;

   ptbl_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .refill_tokens (refill_tokens),
      .window_ticks  (window_ticks)
   );

   ptbl_mem #(
      .NUM_CLIENTS (NUM_CLIENTS)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .clearing (clearing)
   );

   ptbl_pipe #(
      .NUM_CLIENTS (NUM_CLIENTS)
   ) u_pipe (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_client_index     (req_client_index),
      .req_used_tokens      (req_used_tokens),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_limited          (rsp_limited),
      .rsp_remaining_tokens (rsp_remaining_tokens),
      .rsp_index_error      (rsp_index_error),
      .refill_tokens        (refill_tokens),
      .window_ticks         (window_ticks),
      .clearing             (clearing),
      .rd_en                (rd_en),
      .rd_addr              (rd_addr),
      .rd_data              (rd_data),
      .wr_en                (wr_en),
      .wr_addr              (wr_addr),
      .wr_data              (wr_data)
   );

endmodule
